### rtl/cnms_pkg.sv
// shared types, constants and sizes for the canny non-maximum suppression unit
// no dependencies
package cnms_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CFG_WID_W  = COL_W + 1;
   localparam int CFG_HGT_W  = ROW_W + 1;
   localparam int MAG_W      = 8;
   localparam int ANG_W      = 10;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = CFG_WID_W'(640);
   localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = CFG_HGT_W'(480);
   localparam logic [CFG_WID_W-1:0] WIDTH_MIN    = CFG_WID_W'(3);
   localparam logic [CFG_HGT_W-1:0] HEIGHT_MIN   = CFG_HGT_W'(3);
   localparam logic [CFG_WID_W-1:0] WIDTH_MAX    = CFG_WID_W'(MAX_WIDTH);
   localparam logic [CFG_HGT_W-1:0] HEIGHT_MAX   = CFG_HGT_W'(MAX_HEIGHT);

   // register indexes (byte address bit 2)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // angle bounds in half degrees
   localparam logic signed [ANG_W:0] ANG_WRAP = 11'sd360;
   localparam logic signed [ANG_W:0] ANG_FULL = 11'sd720;
   localparam logic signed [ANG_W:0] ANG_B1   = 11'sd45;
   localparam logic signed [ANG_W:0] ANG_B2   = 11'sd135;
   localparam logic signed [ANG_W:0] ANG_B3   = 11'sd225;
   localparam logic signed [ANG_W:0] ANG_B4   = 11'sd315;

   localparam logic [1:0] SECT_HORZ = 2'd0;
   localparam logic [1:0] SECT_DIAG = 2'd1;
   localparam logic [1:0] SECT_VERT = 2'd2;
   localparam logic [1:0] SECT_ANTI = 2'd3;

   typedef struct packed {
      logic [CFG_WID_W-1:0] width;
      logic [CFG_HGT_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [MAG_W-1:0] older;
      logic [MAG_W-1:0] prev;
      logic [ANG_W-1:0] angle;
   } line_type;

   typedef struct packed {
      logic [MAG_W-1:0] center;
      logic [MAG_W-1:0] nbr_a;
      logic [MAG_W-1:0] nbr_b;
      logic             interior;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### rtl/cnms_req_if.sv
// pixel transaction channel (valid/ready) of the suppression unit
// depends on cnms_pkg
interface cnms_req_if import cnms_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic [ANG_W-1:0] angle_half_deg;
   logic             frame_start;

   modport source (output valid, magnitude, angle_half_deg, frame_start, input ready);
   modport sink   (input valid, magnitude, angle_half_deg, frame_start, output ready);
endinterface

### rtl/cnms_rsp_if.sv
// result transaction channel (valid/ready) of the suppression unit
// depends on cnms_pkg
interface cnms_rsp_if import cnms_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] nms_value;
   logic             out_valid;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_col;

   modport source (output valid, nms_value, out_valid, out_row, out_col, input ready);
   modport sink   (input valid, nms_value, out_valid, out_row, out_col, output ready);
endinterface

### rtl/cnms_csr.sv
// apb-style configuration registers, with clamped frame size output
// depends on cnms_pkg
module cnms_csr import cnms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CFG_WID_W-1:0] width_ff, width_in;
   logic [CFG_HGT_W-1:0] height_ff, height_in;
   logic                 wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_IMAGE_WIDTH:  width_in  = csr_pwdata[CFG_WID_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_pwdata[CFG_HGT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (width_ff < WIDTH_MIN)      cfg.width = WIDTH_MIN;
      else if (width_ff > WIDTH_MAX) cfg.width = WIDTH_MAX;
      else                           cfg.width = width_ff;
      if (height_ff < HEIGHT_MIN)      cfg.height = HEIGHT_MIN;
      else if (height_ff > HEIGHT_MAX) cfg.height = HEIGHT_MAX;
      else                             cfg.height = height_ff;
   end

endmodule

### rtl/cnms_front.sv
// front end: position counters, line buffer memory, 3x3 window, direction sector
// depends on cnms_pkg and cnms_req_if
module cnms_front import cnms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   cnms_req_if.sink     req_chan,
   input  logic         q_full,
   output logic         push,
   output item_type     push_item
);

   line_type               line_mem [MAX_WIDTH];
   line_type               line_rd_ff;
   line_type               byp_data_ff;
   logic                   byp_ff;
   line_type               rd_eff;
   line_type               wr_data;

   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_cur;
   logic [COL_W-1:0]       col_cur;
   logic [CFG_WID_W-1:0]   col_inc;
   logic [CFG_HGT_W-1:0]   row_inc;
   logic                   interior;
   logic                   accept;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_adv;
   logic [MAG_W-1:0]       s1_mag_ff;
   logic [ANG_W-1:0]       s1_ang_ff;
   logic [COL_W-1:0]       s1_addr_ff;
   logic                   s1_interior_ff;
   logic [ROW_W-1:0]       s1_row_ff;
   logic [COL_W-1:0]       s1_col_ff;

   logic [MAG_W-1:0]       win_ff [9];
   logic [MAG_W-1:0]       win_in [9];
   logic [ANG_W-1:0]       ca_ff;
   logic signed [ANG_W:0]  ang_s;
   logic [1:0]             sector;

   assign s1_adv         = s1_valid_ff && !q_full;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   // position of the incoming pixel
   always_comb begin
      row_cur  = req_chan.frame_start ? '0 : row_ff;
      col_cur  = req_chan.frame_start ? '0 : col_ff;
      col_inc  = {1'b0, col_cur} + CFG_WID_W'(1);
      row_inc  = {1'b0, row_cur} + CFG_HGT_W'(1);
      interior = (col_cur >= COL_W'(2)) && ({1'b0, col_cur} < cfg.width) &&
                 (row_cur >= ROW_W'(2)) && ({1'b0, row_cur} < cfg.height);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_inc >= cfg.width) begin
            col_in = '0;
            row_in = (row_inc >= cfg.height) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line buffer: read at accept, write back when the item leaves stage one
   assign rd_eff  = byp_ff ? byp_data_ff : line_rd_ff;
   assign wr_data = '{older: rd_eff.prev, prev: s1_mag_ff, angle: s1_ang_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_cur];
      end
      if (s1_adv) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byp_ff         <= s1_adv && (s1_addr_ff == col_cur);
         byp_data_ff    <= wr_data;
         s1_mag_ff      <= req_chan.magnitude;
         s1_ang_ff      <= req_chan.angle_half_deg;
         s1_addr_ff     <= col_cur;
         s1_interior_ff <= interior;
         s1_row_ff      <= interior ? row_cur - ROW_W'(1) : '0;
         s1_col_ff      <= interior ? col_cur - COL_W'(1) : '0;
      end
   end

   // window shift
   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = rd_eff.older;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = rd_eff.prev;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s1_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
         ca_ff <= '0;
      end else if (s1_adv) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
         ca_ff <= rd_eff.angle;
      end
   end

   // sector of the center angle
   always_comb begin
      ang_s = $signed({1'b0, ca_ff});
      if (ang_s > ANG_WRAP) ang_s = ang_s - ANG_FULL;
      if ((ang_s > -ANG_B1 && ang_s <= ANG_B1) || ang_s > ANG_B4 || ang_s <= -ANG_B4) begin
         sector = SECT_HORZ;
      end else if ((ang_s > -ANG_B2 && ang_s <= -ANG_B1) ||
                   (ang_s > ANG_B3 && ang_s <= ANG_B4)) begin
         sector = SECT_DIAG;
      end else if ((ang_s > -ANG_B3 && ang_s <= -ANG_B2) ||
                   (ang_s > ANG_B2 && ang_s <= ANG_B3)) begin
         sector = SECT_VERT;
      end else begin
         sector = SECT_ANTI;
      end
   end

   always_comb begin
      push_item.center   = win_in[4];
      push_item.interior = s1_interior_ff;
      push_item.row      = s1_row_ff;
      push_item.col      = s1_col_ff;
      case (sector)
         SECT_HORZ: begin
            push_item.nbr_a = win_in[3];
            push_item.nbr_b = win_in[5];
         end
         SECT_DIAG: begin
            push_item.nbr_a = win_in[0];
            push_item.nbr_b = win_in[8];
         end
         SECT_VERT: begin
            push_item.nbr_a = win_in[1];
            push_item.nbr_b = win_in[7];
         end
         default: begin
            push_item.nbr_a = win_in[6];
            push_item.nbr_b = win_in[2];
         end
      endcase
   end

   assign push = s1_adv;

endmodule

### rtl/cnms_queue.sv
// two-entry queue of classified pixels between front and back end
// depends on cnms_pkg
module cnms_queue import cnms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  item_type      push_item,
   input  logic          pop,
   output item_type      pop_item,
   output q_status_type  status
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.full  = cnt_ff[1];
   assign status.empty = (cnt_ff == 2'd0);

endmodule

### rtl/cnms_back.sv
// back end: local maximum compare and result output register
// depends on cnms_pkg and cnms_rsp_if
module cnms_back import cnms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  q_status_type  q_status,
   input  item_type      pop_item,
   output logic          pop,
   cnms_rsp_if.source    rsp_chan
);

   logic             rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0] nms_ff, nms_in;
   logic             out_valid_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;

   assign pop          = !q_status.empty && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = pop ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign nms_in       = (pop_item.interior && pop_item.center > pop_item.nbr_a &&
                          pop_item.center > pop_item.nbr_b) ? pop_item.center : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         nms_ff       <= nms_in;
         out_valid_ff <= pop_item.interior;
         row_ff       <= pop_item.row;
         col_ff       <= pop_item.col;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.nms_value = nms_ff;
   assign rsp_chan.out_valid = out_valid_ff;
   assign rsp_chan.out_row   = row_ff;
   assign rsp_chan.out_col   = col_ff;

endmodule

### rtl/canny_non_maximum_suppression_unit.sv
// Canny non-maximum suppression, four directions, over a raster pixel stream. Every accepted
// pixel gives one result for the pixel one row and one column back; results on the frame
// border come out with out_valid low and all fields zero. The unit takes one pixel per clock
// and keeps that rate as long as results are taken; a pixel's result passes from the line
// buffer read stage through the queue to the output register. The line buffer is a
// single-port-write memory of MAX_WIDTH entries read once per pixel. Frame size registers
// sit at byte addresses 0 (width) and 4 (height) and should be written only while the unit
// holds no pixels in flight.
// depends on cnms_pkg, cnms_req_if, cnms_rsp_if, cnms_csr, cnms_front, cnms_queue, cnms_back
module canny_non_maximum_suppression_unit import cnms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cnms_req_if.sink              req_chan,
   cnms_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg;
   logic          push;
   logic          pop;
   item_type      push_item;
   item_type      pop_item;
   q_status_type  q_status;

   cnms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cnms_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .q_full    (q_status.full),
      .push      (push),
      .push_item (push_item)
   );

   cnms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   cnms_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("pop from an empty queue");

   a_interior_position: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.out_valid |-> rsp_chan.out_row != '0 && rsp_chan.out_col != '0)
      else $error("interior result on the frame border");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.out_valid |-> rsp_chan.nms_value == '0)
      else $error("border result carries a magnitude");

endmodule

### dv/tb_canny_non_maximum_suppression_unit.sv
`timescale 1ns / 1ps
// testbench for canny_non_maximum_suppression_unit: directed and random pixel streams over
// several frame sizes, checked per result against typed rows or a behavioral suppression predictor
// depends on cnms_pkg, cnms_req_if, cnms_rsp_if and the unit itself
module tb_canny_non_maximum_suppression_unit import cnms_pkg::*; ();

   localparam int DIRECTED_ROWS     = 25;
   localparam int DIRECTED_AT_RESET = 4;
   localparam int SETTLE_CYCLES     = 12;
   localparam int HOLDOFF_CYCLES    = 64;
   localparam int REPORT_CAP        = 100;
   localparam int RUN_LIMIT_NS      = 2_000_000;

   typedef struct packed {
      logic [MAG_W-1:0] value;
      logic             valid;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } nms_result_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic [ANG_W-1:0] ang;
      logic             sof;
      logic             typed;
      nms_result_type   res;
   } directed_row_type;

   logic clock;
   logic reset;

   cnms_req_if pix_if();
   cnms_rsp_if nms_if();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   canny_non_maximum_suppression_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (pix_if),
      .rsp_chan    (nms_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [CFG_WID_W-1:0] cfg_width;
   logic [CFG_HGT_W-1:0] cfg_height;
   logic [MAG_W-1:0]     mag_older [MAX_WIDTH];
   logic [MAG_W-1:0]     mag_prev  [MAX_WIDTH];
   logic [ANG_W-1:0]     ang_prev  [MAX_WIDTH];
   logic [MAG_W-1:0]     win [9];
   logic [ANG_W-1:0]     ctr_ang [2];
   int unsigned          row_pos;
   int unsigned          col_pos;

   nms_result_type pending_nms [$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          holds_asked    = 0;
   int          holds_started  = 0;
   int          hold_left      = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // after reset, default frame size: every result lies before the frame
      '{8'd255, 10'd1023, 1'b1, 1'b1, '{8'd0, 1'b0, 12'd0, 10'd0}},
      '{8'd0,   10'd0,    1'b0, 1'b1, '{8'd0, 1'b0, 12'd0, 10'd0}},
      '{8'd128, 10'd720,  1'b0, 1'b1, '{8'd0, 1'b0, 12'd0, 10'd0}},
      '{8'd1,   10'd360,  1'b0, 1'b1, '{8'd0, 1'b0, 12'd0, 10'd0}},
      // three-wide frame, center angles on, next to and between the sector bounds
      '{8'd10,  10'd0,    1'b1, 1'b0, '0},
      '{8'd20,  10'd0,    1'b0, 1'b0, '0},
      '{8'd30,  10'd0,    1'b0, 1'b0, '0},
      '{8'd40,  10'd0,    1'b0, 1'b0, '0},
      '{8'd200, 10'd90,   1'b0, 1'b0, '0},
      '{8'd40,  10'd0,    1'b0, 1'b0, '0},
      '{8'd50,  10'd0,    1'b0, 1'b0, '0},
      '{8'd60,  10'd46,   1'b0, 1'b0, '0},
      '{8'd200, 10'd0,    1'b0, 1'b0, '0},
      '{8'd10,  10'd0,    1'b0, 1'b0, '0},
      '{8'd60,  10'd135,  1'b0, 1'b0, '0},
      '{8'd60,  10'd0,    1'b0, 1'b0, '0},
      '{8'd0,   10'd0,    1'b0, 1'b0, '0},
      '{8'd255, 10'd136,  1'b0, 1'b0, '0},
      '{8'd0,   10'd0,    1'b0, 1'b0, '0},
      '{8'd255, 10'd0,    1'b0, 1'b0, '0},
      '{8'd255, 10'd225,  1'b0, 1'b0, '0},
      '{8'd255, 10'd0,    1'b0, 1'b0, '0},
      '{8'd1,   10'd0,    1'b0, 1'b0, '0},
      '{8'd2,   10'd226,  1'b0, 1'b0, '0},
      '{8'd3,   10'd0,    1'b0, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

   task automatic clear_predictor();
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         mag_older[i] = '0;
         mag_prev[i]  = '0;
         ang_prev[i]  = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      ctr_ang[0] = '0;
      ctr_ang[1] = '0;
      row_pos    = 0;
      col_pos    = 0;
   endtask

   function automatic logic [MAG_W-1:0] suppressed_center(logic [ANG_W-1:0] ang);
      logic signed [ANG_W:0] a;
      logic [1:0]            sector;
      logic [MAG_W-1:0]      n1, n2;
      a = $signed({1'b0, ang});
      if (a > ANG_WRAP) a = a - ANG_FULL;
      if ((a > -ANG_B1 && a <= ANG_B1) || a > ANG_B4 || a <= -ANG_B4) sector = SECT_HORZ;
      else if ((a > -ANG_B2 && a <= -ANG_B1) || (a > ANG_B3 && a <= ANG_B4)) sector = SECT_DIAG;
      else if ((a > -ANG_B3 && a <= -ANG_B2) || (a > ANG_B2 && a <= ANG_B3)) sector = SECT_VERT;
      else sector = SECT_ANTI;
      case (sector)
         SECT_HORZ: begin n1 = win[3]; n2 = win[5]; end
         SECT_DIAG: begin n1 = win[0]; n2 = win[8]; end
         SECT_VERT: begin n1 = win[1]; n2 = win[7]; end
         default:   begin n1 = win[6]; n2 = win[2]; end
      endcase
      return (win[4] > n1 && win[4] > n2) ? win[4] : '0;
   endfunction

   function automatic nms_result_type predict_nms(logic [MAG_W-1:0] mag, logic [ANG_W-1:0] ang,
                                                  logic sof);
      int unsigned w, h, r, c, idx;
      nms_result_type res;
      w = (cfg_width < WIDTH_MIN) ? int'(WIDTH_MIN) :
          (cfg_width > WIDTH_MAX) ? MAX_WIDTH : int'(cfg_width);
      h = (cfg_height < HEIGHT_MIN) ? int'(HEIGHT_MIN) :
          (cfg_height > HEIGHT_MAX) ? MAX_HEIGHT : int'(cfg_height);
      if (sof) begin
         row_pos = 0;
         col_pos = 0;
      end
      r   = row_pos;
      c   = col_pos;
      idx = c % MAX_WIDTH;
      for (int k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2]         = mag_older[idx];
      win[5]         = mag_prev[idx];
      win[8]         = mag;
      ctr_ang[1]     = ctr_ang[0];
      ctr_ang[0]     = ang_prev[idx];
      mag_older[idx] = mag_prev[idx];
      mag_prev[idx]  = mag;
      ang_prev[idx]  = ang;
      res = '0;
      if (r >= 2 && r - 1 <= h - 2 && c >= 2 && c - 1 <= w - 2) begin
         res.value = suppressed_center(ctr_ang[1]);
         res.valid = 1'b1;
         res.row   = ROW_W'(r - 1);
         res.col   = COL_W'(c - 1);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
      return res;
   endfunction

   function automatic logic [MAG_W-1:0] random_magnitude();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 70) return MAG_W'($urandom_range(255, 0));
      if (roll < 85) return MAG_W'($urandom_range(3, 0));
      return MAG_W'($urandom_range(255, 252));
   endfunction

   function automatic logic [ANG_W-1:0] random_angle();
      int unsigned roll;
      int          bound;
      roll = $urandom_range(99, 0);
      if (roll < 50) return ANG_W'($urandom_range(720, 0));
      if (roll < 65) return ANG_W'($urandom_range(1023, 0));
      // land on or next to a sector bound, positive or wrapped negative
      case ($urandom_range(5, 0))
         0:       bound = int'(ANG_B1);
         1:       bound = int'(ANG_B2);
         2:       bound = int'(ANG_B3);
         3:       bound = int'(ANG_B4);
         4:       bound = int'(ANG_WRAP);
         default: bound = int'(ANG_FULL);
      endcase
      if ($urandom_range(1, 0) == 1) bound = int'(ANG_FULL) - bound;
      return ANG_W'(bound + int'($urandom_range(2, 0)) - 1);
   endfunction

   task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_CAP)
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      end
   endtask

   task automatic check_result();
      nms_result_type want;
      if (pending_nms.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_CAP)
            $display("%0t: result transaction with none expected: value %0d valid %0b row %0d col %0d",
                     $time, nms_if.nms_value, nms_if.out_valid, nms_if.out_row, nms_if.out_col);
      end else begin
         want = pending_nms.pop_front();
         check_field("nms_value", 16'(want.value), 16'(nms_if.nms_value));
         check_field("out_valid", 16'(want.valid), 16'(nms_if.out_valid));
         check_field("out_row", 16'(want.row), 16'(nms_if.out_row));
         check_field("out_col", 16'(want.col), 16'(nms_if.out_col));
      end
   endtask

   // result side: check, then pick ready for the next cycle
   initial begin
      nms_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && nms_if.valid && nms_if.ready) check_result();
         if (holds_started != holds_asked) begin
            holds_started = holds_asked;
            hold_left     = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            nms_if.ready <= 1'b0;
         end else begin
            nms_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   task automatic send_pixel(logic [MAG_W-1:0] mag, logic [ANG_W-1:0] ang, logic sof,
                             logic typed, nms_result_type typed_res);
      nms_result_type res;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         pix_if.valid <= 1'b0;
         @(posedge clock);
      end
      pix_if.valid          <= 1'b1;
      pix_if.magnitude      <= mag;
      pix_if.angle_half_deg <= ang;
      pix_if.frame_start    <= sof;
      @(posedge clock);
      while (!pix_if.ready) @(posedge clock);
      res = predict_nms(mag, ang, sof);
      pending_nms.push_back(typed ? typed_res : res);
   endtask

   task automatic csr_write(logic reg_sel, int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_sel == REG_IMAGE_WIDTH) cfg_width = CFG_WID_W'(value);
      else cfg_height = CFG_HGT_W'(value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      pix_if.valid <= 1'b0;
      while (pending_nms.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned width_val, int unsigned height_val,
                            int unsigned item_count, int send_pct, int recv_pct,
                            bit with_holdoff);
      drain_results();
      csr_write(REG_IMAGE_WIDTH, width_val);
      csr_write(REG_IMAGE_HEIGHT, height_val);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int unsigned i = 0; i < item_count; i++) begin
         if (with_holdoff && i == item_count / 3) holds_asked++;
         send_pixel(random_magnitude(), random_angle(),
                    (i == 0) || ($urandom_range(299, 0) == 0), 1'b0, '0);
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      pix_if.valid          <= 1'b0;
      pix_if.magnitude      <= '0;
      pix_if.angle_half_deg <= '0;
      pix_if.frame_start    <= 1'b0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      clear_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (i == DIRECTED_AT_RESET) begin
            drain_results();
            csr_write(REG_IMAGE_WIDTH, 3);
            csr_write(REG_IMAGE_HEIGHT, MAX_HEIGHT);
         end
         send_pixel(directed_rows[i].mag, directed_rows[i].ang, directed_rows[i].sof,
                    directed_rows[i].typed, directed_rows[i].res);
      end

      run_phase(7, 5, 250, 0, 0, 1'b1);
      run_phase(1, 2, 150, 48, 0, 1'b0);
      run_phase(16, 8191, 250, 0, 48, 1'b0);
      run_phase(MAX_WIDTH, 3, 120, 8, 8, 1'b0);
      run_phase(2047, 3, 80, 0, 0, 1'b0);
      run_phase(12, 6, 400, 0, 48, 1'b1);
      run_phase(5, MAX_HEIGHT, 300, 48, 0, 1'b0);
      run_phase(9, 3, 250, 8, 8, 1'b0);
      run_phase(0, 0, 100, 8, 8, 1'b0);
      drain_results();

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
